// ===== sv/bss_pkg.sv =====
// Boot slot selector package: reset values of the configuration registers,
// register indexes and the classified header word passed from front to back.
// No dependencies.
package bss_pkg;

  localparam int SLOT_COUNT = 2;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [31:0] MAGIC_RESET  = 32'h544F_4952;
  localparam logic [31:0] FIRST_RESET  = 32'h0000_2100;
  localparam logic [31:0] STRIDE_RESET = 32'h0007_F000;

  localparam logic [15:0] FLETCHER_SEED = 16'hFFFF;

  typedef enum logic [1:0] {
    REG_EXPECTED_MAGIC      = 2'd0,
    REG_FIRST_IMAGE_ADDRESS = 2'd1,
    REG_SLOT_STRIDE         = 2'd2
  } reg_index_t;

  // Header after the front end: raw Fletcher sums (not yet folded) and the
  // outcome of the magic, slot range and address checks.
  typedef struct packed {
    logic [18:0] sum_a;
    logic [20:0] sum_b;
    logic [31:0] checksum;
    logic        fields_ok;
    logic [31:0] version;
    logic [31:0] start_address;
    logic [3:0]  slot;
    logic        last;
  } bss_word_t;

endpackage

// ===== sv/bss_front.sv =====
// Boot slot selector front end: configuration registers and header classify
// (magic, slot range, address compare, Fletcher sums). Uses bss_pkg.
module bss_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [31:0]       cfg_data,
  input  logic [31:0]       hdr_magic,
  input  logic [31:0]       hdr_version,
  input  logic [31:0]       hdr_start_address,
  input  logic [31:0]       hdr_checksum,
  input  logic [3:0]        slot_number,
  input  logic              final_slot,
  output bss_pkg::bss_word_t word
);
  import bss_pkg::*;

  logic [31:0] expected_magic;
  logic [31:0] first_image_address;
  logic [31:0] slot_stride;

  logic [15:0] halves [6];
  logic [18:0] acc_a;
  logic [20:0] acc_b;
  logic [31:0] exp_addr;
  logic        slot_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_magic      <= MAGIC_RESET;
      first_image_address <= FIRST_RESET;
      slot_stride         <= STRIDE_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_EXPECTED_MAGIC:      expected_magic      <= cfg_data;
        REG_FIRST_IMAGE_ADDRESS: first_image_address <= cfg_data;
        REG_SLOT_STRIDE:         slot_stride         <= cfg_data;
        default: ;
      endcase
    end
  end

  // little-endian halves, low half first
  always_comb begin
    halves[0] = hdr_magic[15:0];
    halves[1] = hdr_magic[31:16];
    halves[2] = hdr_version[15:0];
    halves[3] = hdr_version[31:16];
    halves[4] = hdr_start_address[15:0];
    halves[5] = hdr_start_address[31:16];
    acc_a = {3'd0, FLETCHER_SEED};
    acc_b = {5'd0, FLETCHER_SEED};
    for (int i = 0; i < 6; i++) begin
      acc_a = acc_a + {3'd0, halves[i]};
      acc_b = acc_b + {2'd0, acc_a};
    end
  end

  assign exp_addr = first_image_address + ({28'd0, slot_number} * slot_stride);
  assign slot_ok  = ({1'b0, slot_number} < 5'(SLOT_COUNT));

  always_comb begin
    word.sum_a         = acc_a;
    word.sum_b         = acc_b;
    word.checksum      = hdr_checksum;
    word.fields_ok     = slot_ok && (hdr_magic == expected_magic)
                         && (hdr_start_address == exp_addr);
    word.version       = hdr_version;
    word.start_address = hdr_start_address;
    word.slot          = slot_number;
    word.last          = final_slot;
  end

endmodule

// ===== sv/bss_queue.sv =====
// Boot slot selector queue: two-entry FIFO of classified header words
// between front and back. Uses bss_pkg.
module bss_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  bss_pkg::bss_word_t push_word,
  output logic               full,
  input  logic               pop,
  output logic               head_valid,
  output bss_pkg::bss_word_t head_word
);
  import bss_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  bss_word_t        entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;

  assign full       = (count == (PTR_W+1)'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_word  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_word;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      priority case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: ;
      endcase
    end
  end

endmodule

// ===== sv/bss_back.sv =====
// Boot slot selector back end: checksum fold and compare, best-slot tracking
// and the result register. Uses bss_pkg.
module bss_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  bss_pkg::bss_word_t head_word,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               boot_found,
  output logic [3:0]         boot_slot,
  output logic [31:0]        boot_address,
  output logic [31:0]        boot_version
);
  import bss_pkg::*;

  logic [31:0] lead_version;
  logic [3:0]  lead_slot;
  logic [31:0] lead_address;
  logic        any_valid_seen;

  logic [16:0] a_fold1, a_fold2;
  logic [16:0] b_fold1, b_fold2;
  logic [31:0] calc_checksum;
  logic        hdr_ok;
  logic        take;
  logic [31:0] version_next;
  logic [3:0]  slot_next;
  logic [31:0] address_next;
  logic        any_next;

  // second fold always lands in 16 bits
  assign a_fold1 = {1'b0, head_word.sum_a[15:0]} + {14'd0, head_word.sum_a[18:16]};
  assign a_fold2 = {1'b0, a_fold1[15:0]} + {16'd0, a_fold1[16]};
  assign b_fold1 = {1'b0, head_word.sum_b[15:0]} + {12'd0, head_word.sum_b[20:16]};
  assign b_fold2 = {1'b0, b_fold1[15:0]} + {16'd0, b_fold1[16]};
  assign calc_checksum = {b_fold2[15:0], a_fold2[15:0]};

  assign hdr_ok = head_word.fields_ok && (calc_checksum == head_word.checksum);
  assign take   = hdr_ok && (!any_valid_seen || (head_word.version > lead_version));

  // final words wait for room in the result register
  assign pop = head_valid && (!head_word.last || !out_valid || out_ready);

  always_comb begin
    version_next = take ? head_word.version       : lead_version;
    slot_next    = take ? head_word.slot          : lead_slot;
    address_next = take ? head_word.start_address : lead_address;
    any_next     = take || any_valid_seen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      lead_version   <= '0;
      lead_slot      <= '0;
      lead_address   <= '0;
      any_valid_seen <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (pop && head_word.last) begin
        lead_version   <= '0;
        lead_slot      <= '0;
        lead_address   <= '0;
        any_valid_seen <= 1'b0;
        out_valid      <= 1'b1;
      end else begin
        if (pop) begin
          lead_version   <= version_next;
          lead_slot      <= slot_next;
          lead_address   <= address_next;
          any_valid_seen <= any_next;
        end
        if (out_ready) out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_word.last) begin
      boot_found   <= any_next;
      boot_slot    <= slot_next;
      boot_address <= address_next;
      boot_version <= version_next;
    end
  end

endmodule

// ===== sv/boot_slot_selector_unit.sv =====
// Boot slot selector top level: front classify, two-word queue, back select.
// Uses bss_pkg, bss_front, bss_queue, bss_back.
//
//   channel  direction  handshake             payload
//   cfg      in         cfg_we                cfg_index, cfg_data
//   in       in         in_valid / in_ready   hdr_*, slot_number, final_slot
//   out      out        out_valid / out_ready boot_found, boot_slot, boot_address, boot_version
//
// One header word per cycle while the queue is not full. A final word passes
// through the queue entry and then the result register before out_valid rises.
// in_ready drops only when the two-entry queue is full, which happens when a
// final word waits for a result register still held by out_ready low.
// Synchronous reset restores the register defaults and clears the scan state.
module boot_slot_selector_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] hdr_magic,
  input  logic [31:0] hdr_version,
  input  logic [31:0] hdr_start_address,
  input  logic [31:0] hdr_checksum,
  input  logic [3:0]  slot_number,
  input  logic        final_slot,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        boot_found,
  output logic [3:0]  boot_slot,
  output logic [31:0] boot_address,
  output logic [31:0] boot_version
);
  import bss_pkg::*;

  bss_word_t front_word;
  bss_word_t head_word;
  logic      q_full;
  logic      head_valid;
  logic      pop;

  assign in_ready = !q_full;

  bss_front u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .hdr_magic         (hdr_magic),
    .hdr_version       (hdr_version),
    .hdr_start_address (hdr_start_address),
    .hdr_checksum      (hdr_checksum),
    .slot_number       (slot_number),
    .final_slot        (final_slot),
    .word              (front_word)
  );

  bss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (in_valid && !q_full),
    .push_word  (front_word),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_word  (head_word)
  );

  bss_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head_word    (head_word),
    .pop          (pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .boot_found   (boot_found),
    .boot_slot    (boot_slot),
    .boot_address (boot_address),
    .boot_version (boot_version)
  );

endmodule

// ===== tb/sv/boot_slot_selector_unit_test.sv =====
// Self-checking bench for boot_slot_selector_unit: slot header scans in, boot
// decisions out, predicted by an in-bench slot chooser and compared per field.
// Depends on bss_pkg and the boot_slot_selector_unit RTL.
module boot_slot_selector_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import bss_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int IDLE_PCT = 14;
  localparam int SETTLE_CYCLES = 6;
  localparam int RANDOM_HEADERS = 540;
  localparam int BATCH_HEADERS = 120;

  typedef struct {
    logic [31:0] magic;
    logic [31:0] version;
    logic [31:0] start_address;
    logic [31:0] checksum;
    logic [3:0]  slot;
    logic        last;
  } slot_header_t;

  typedef struct {
    logic        found;
    logic [3:0]  slot;
    logic [31:0] address;
    logic [31:0] version;
  } boot_choice_t;

  typedef enum int {
    FLAW_MAGIC,
    FLAW_CHECKSUM,
    FLAW_VERSION,
    FLAW_ADDRESS,
    FLAW_SLOT,
    FLAW_NOISE
  } flaw_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] hdr_magic;
  logic [31:0] hdr_version;
  logic [31:0] hdr_start_address;
  logic [31:0] hdr_checksum;
  logic [3:0]  slot_number;
  logic        final_slot;
  logic        out_valid;
  logic        out_ready;
  logic        boot_found;
  logic [3:0]  boot_slot;
  logic [31:0] boot_address;
  logic [31:0] boot_version;

  // chooser copy of the configuration and scan state
  logic [31:0] magic_reg;
  logic [31:0] base_reg;
  logic [31:0] stride_reg;
  logic [31:0] chosen_version;
  logic [3:0]  chosen_slot;
  logic [31:0] chosen_address;
  logic        seen_valid;

  boot_choice_t pending_choices[$];
  int mismatches;
  int headers_accepted;
  int hold_request;
  bit steady;

  boot_slot_selector_unit u_dut (
    .clk               (clk),
    .rst               (rst),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .hdr_magic         (hdr_magic),
    .hdr_version       (hdr_version),
    .hdr_start_address (hdr_start_address),
    .hdr_checksum      (hdr_checksum),
    .slot_number       (slot_number),
    .final_slot        (final_slot),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .boot_found        (boot_found),
    .boot_slot         (boot_slot),
    .boot_address      (boot_address),
    .boot_version      (boot_version)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2ms;
    $display("boot_slot_selector_unit test failed");
    $finish;
  end

  // Fletcher-32 over three words as six 16-bit halves, low half first
  function automatic logic [31:0] fletcher32_of(logic [31:0] w0, logic [31:0] w1,
                                                logic [31:0] w2);
    logic [95:0] halves;
    logic [31:0] sum_a;
    logic [31:0] sum_b;
    halves = {w2, w1, w0};
    sum_a = {16'h0, FLETCHER_SEED};
    sum_b = {16'h0, FLETCHER_SEED};
    for (int i = 0; i < 6; i++) begin
      sum_a = sum_a + {16'h0, halves[16*i +: 16]};
      sum_b = sum_b + sum_a;
    end
    repeat (2) begin
      sum_a = {16'h0, sum_a[15:0]} + {16'h0, sum_a[31:16]};
      sum_b = {16'h0, sum_b[15:0]} + {16'h0, sum_b[31:16]};
    end
    return {sum_b[15:0], sum_a[15:0]};
  endfunction

  function automatic logic [31:0] slot_address(logic [3:0] slot);
    return base_reg + 32'(slot) * stride_reg;
  endfunction

  function automatic slot_header_t well_formed(logic [3:0] slot, logic [31:0] version,
                                               logic last);
    slot_header_t h;
    h.magic = magic_reg;
    h.version = version;
    h.slot = slot;
    h.last = last;
    h.start_address = slot_address(slot);
    h.checksum = fletcher32_of(h.magic, h.version, h.start_address);
    return h;
  endfunction

  function automatic slot_header_t flawed(slot_header_t h, flaw_t flaw);
    slot_header_t b;
    logic [31:0] bit_mask;
    b = h;
    bit_mask = 32'h1 << $urandom_range(31);
    case (flaw)
      FLAW_MAGIC:    b.magic = b.magic ^ bit_mask;
      FLAW_CHECKSUM: b.checksum = b.checksum ^ bit_mask;
      FLAW_VERSION:  b.version = b.version ^ bit_mask;
      FLAW_ADDRESS:  b.start_address = b.start_address ^ bit_mask;
      FLAW_SLOT: begin
        b.slot = 4'($urandom_range(15, SLOT_COUNT));
        b.start_address = slot_address(b.slot);
      end
      default: begin
        b.magic = $urandom;
        b.version = $urandom;
        b.start_address = $urandom;
        b.checksum = $urandom;
        b.slot = 4'($urandom);
      end
    endcase
    // keep the checksum right so only the intended check fails
    if (flaw == FLAW_MAGIC || flaw == FLAW_ADDRESS || flaw == FLAW_SLOT)
      b.checksum = fletcher32_of(b.magic, b.version, b.start_address);
    return b;
  endfunction

  function automatic void choose_slot(slot_header_t h);
    boot_choice_t c;
    logic ok;
    ok = (h.slot < SLOT_COUNT) && (h.magic == magic_reg)
      && (fletcher32_of(h.magic, h.version, h.start_address) == h.checksum)
      && (h.start_address == slot_address(h.slot));
    if (ok && (!seen_valid || h.version > chosen_version)) begin
      chosen_version = h.version;
      chosen_slot = h.slot;
      chosen_address = h.start_address;
      seen_valid = 1'b1;
    end
    if (h.last) begin
      c.found = seen_valid;
      c.slot = chosen_slot;
      c.address = chosen_address;
      c.version = chosen_version;
      pending_choices.push_back(c);
      chosen_version = '0;
      chosen_slot = '0;
      chosen_address = '0;
      seen_valid = 1'b0;
    end
  endfunction

  task automatic send_header(slot_header_t h);
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    hdr_magic <= h.magic;
    hdr_version <= h.version;
    hdr_start_address <= h.start_address;
    hdr_checksum <= h.checksum;
    slot_number <= h.slot;
    final_slot <= h.last;
    do @(posedge clk); while (!in_ready);
    choose_slot(h);
    headers_accepted++;
  endtask

  // stop offering words, let every decision drain, then give the pipe time
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_choices.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] index, logic [31:0] data);
    cfg_we <= 1'b1;
    cfg_index <= index;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (index)
      REG_EXPECTED_MAGIC:      magic_reg = data;
      REG_FIRST_IMAGE_ADDRESS: base_reg = data;
      REG_SLOT_STRIDE:         stride_reg = data;
      default: ;
    endcase
  endtask

  // receiver: random stalls, or a long hold-off when one is requested
  initial begin
    int hold_left;
    hold_left = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : check_result
    boot_choice_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_choices.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected word, expected none actual found=%b slot=%h addr=%h ver=%h",
                 $time, boot_found, boot_slot, boot_address, boot_version);
      end else begin
        want = pending_choices.pop_front();
        check_field("boot_found", 32'(want.found), 32'(boot_found));
        check_field("boot_slot", 32'(want.slot), 32'(boot_slot));
        check_field("boot_address", want.address, boot_address);
        check_field("boot_version", want.version, boot_version);
      end
    end
  end

  task automatic test_selection();
    send_header(well_formed(4'd0, 32'd7, 1'b1));
    send_header(well_formed(4'd1, 32'hFFFF_FFFF, 1'b0));
    send_header(well_formed(4'd0, 32'd0, 1'b1));
    // equal versions: earlier slot stays
    send_header(well_formed(4'd0, 32'd5, 1'b0));
    send_header(well_formed(4'd1, 32'd5, 1'b1));
    // first valid header taken even at version zero
    send_header(well_formed(4'd1, 32'd0, 1'b0));
    send_header(flawed(well_formed(4'd0, 32'd9, 1'b1), FLAW_CHECKSUM));
    send_header(well_formed(4'd0, 32'd3, 1'b0));
    send_header(well_formed(4'd1, 32'd9, 1'b1));
  endtask

  task automatic test_invalid_headers();
    slot_header_t h;
    send_header(flawed(well_formed(4'd0, 32'd4, 1'b0), FLAW_MAGIC));
    send_header(flawed(well_formed(4'd1, 32'd4, 1'b0), FLAW_CHECKSUM));
    send_header(flawed(well_formed(4'd0, 32'd4, 1'b1), FLAW_ADDRESS));
    h = '{32'h0, 32'h0, 32'h0, 32'h0, 4'h0, 1'b1};
    send_header(h);
    h = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF, 1'b1};
    send_header(h);
  endtask

  task automatic test_slot_range();
    send_header(well_formed(4'd2, 32'd8, 1'b0));
    send_header(well_formed(4'd15, 32'd9, 1'b1));
    send_header(well_formed(4'd1, 32'd2, 1'b0));
    send_header(flawed(well_formed(4'd15, 32'd3, 1'b1), FLAW_NOISE));
  endtask

  task automatic test_registers();
    settle();
    write_reg(REG_EXPECTED_MAGIC, 32'h0);
    write_reg(REG_FIRST_IMAGE_ADDRESS, 32'h0);
    write_reg(REG_SLOT_STRIDE, 32'h0);
    write_reg(REG_UNUSED, $urandom);
    send_header(well_formed(4'd0, 32'd1, 1'b0));
    send_header(well_formed(4'd1, 32'd2, 1'b1));
    settle();
    write_reg(REG_EXPECTED_MAGIC, 32'hFFFF_FFFF);
    write_reg(REG_FIRST_IMAGE_ADDRESS, 32'hFFFF_FFFF);
    write_reg(REG_SLOT_STRIDE, 32'hFFFF_FFFF);
    send_header(well_formed(4'd1, 32'd10, 1'b0));
    send_header(well_formed(4'd0, 32'd3, 1'b1));
    settle();
  endtask

  // output held off while final words keep coming: the queue fills, in_ready drops
  task automatic test_backpressure();
    settle();
    steady = 1'b1;
    hold_request = 80;
    for (int i = 0; i < 12; i++)
      send_header(well_formed(4'($urandom_range(SLOT_COUNT - 1)), $urandom, 1'b1));
    settle();
    steady = 1'b0;
  endtask

  function automatic logic [31:0] pick_version();
    case ($urandom_range(3))
      0:       return 32'($urandom_range(3));
      1:       return 32'hFFFF_FFFF - 32'($urandom_range(1));
      default: return $urandom;
    endcase
  endfunction

  task automatic random_config();
    write_reg(REG_EXPECTED_MAGIC, $urandom);
    write_reg(REG_FIRST_IMAGE_ADDRESS, $urandom);
    case ($urandom_range(3))
      0:       write_reg(REG_SLOT_STRIDE, 32'h0);
      1:       write_reg(REG_SLOT_STRIDE, 32'hFFFF_FFFF);
      2:       write_reg(REG_SLOT_STRIDE, 32'($urandom_range(32'h10_0000)));
      default: write_reg(REG_SLOT_STRIDE, $urandom);
    endcase
    if ($urandom_range(1) == 0) write_reg(REG_UNUSED, $urandom);
  endtask

  task automatic test_random_scans();
    int target;
    int batch;
    int scan_len;
    slot_header_t h;
    target = headers_accepted + RANDOM_HEADERS;
    batch = 0;
    while (headers_accepted < target) begin
      settle();
      if (batch > 0) random_config();
      steady = (batch == 2);
      repeat (BATCH_HEADERS / 3) begin
        scan_len = $urandom_range(4, 1);
        for (int k = 0; k < scan_len; k++) begin
          h = well_formed(4'($urandom_range(SLOT_COUNT - 1)), pick_version(),
                          k == scan_len - 1);
          if ($urandom_range(99) >= 70)
            h = flawed(h, flaw_t'($urandom_range(FLAW_NOISE)));
          send_header(h);
        end
      end
      batch++;
    end
    settle();
    steady = 1'b0;
  endtask

  initial begin
    magic_reg = MAGIC_RESET;
    base_reg = FIRST_RESET;
    stride_reg = STRIDE_RESET;
    chosen_version = '0;
    chosen_slot = '0;
    chosen_address = '0;
    seen_valid = 1'b0;
    mismatches = 0;
    headers_accepted = 0;
    hold_request = 0;
    steady = 1'b0;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_EXPECTED_MAGIC;
    cfg_data <= '0;
    in_valid <= 1'b0;
    hdr_magic <= '0;
    hdr_version <= '0;
    hdr_start_address <= '0;
    hdr_checksum <= '0;
    slot_number <= '0;
    final_slot <= 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_selection();
    test_invalid_headers();
    test_slot_range();
    test_registers();
    test_backpressure();
    test_random_scans();
    settle();

    if (mismatches == 0) begin
      $display("boot_slot_selector_unit test passed");
    end else begin
      $display("boot_slot_selector_unit test failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/bss_pkg.sv
sv/bss_front.sv
sv/bss_queue.sv
sv/bss_back.sv
sv/boot_slot_selector_unit.sv
tb/sv/boot_slot_selector_unit_test.sv
